// ----- sv/mpa_pkg.sv -----
package mpa_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int CAL_BITS    = 12;
   localparam int THR_BITS    = 7;
   localparam int CMP_BITS    = (SAMPLE_BITS > CAL_BITS) ? SAMPLE_BITS : CAL_BITS;
   localparam int NUM_BITS    = 22;
   localparam int TENTHS_BITS = 10;
   localparam int WHOLE_BITS  = 7;
   localparam int DIGIT_BITS  = 4;
   localparam int CNT_BITS    = $clog2(NUM_BITS);
   localparam int CSR_IDX_BITS = 2;

   localparam logic [NUM_BITS-1:0]    SCALE_TENTHS = NUM_BITS'(1000);
   localparam int                     DIV10_BITS   = TENTHS_BITS + 13;
   localparam logic [DIV10_BITS-1:0]  DIV10_MUL    = DIV10_BITS'(6554);
   localparam int                     DIV10_SHIFT  = 16;
   localparam logic [WHOLE_BITS-1:0]  SATURATED_PERCENT = WHOLE_BITS'(85);

   localparam logic [CAL_BITS-1:0] DRY_RESET = CAL_BITS'(4095);
   localparam logic [CAL_BITS-1:0] WET_RESET = CAL_BITS'(0);
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(30);

   localparam logic [1:0] LED_OK  = 2'd0;
   localparam logic [1:0] LED_WET = 2'd1;
   localparam logic [1:0] LED_RED = 2'd2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DRY_LEVEL       = 2'd0,
      CSR_WET_LEVEL       = 2'd1,
      CSR_ALARM_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_SCALE,
      ST_SPLIT
   } state_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw_sample;
      logic                   mute_active;
   } req_payload_type;

   typedef struct packed {
      logic [WHOLE_BITS-1:0] percent_whole;
      logic [DIGIT_BITS-1:0] percent_tenth;
      logic                  alarm;
      logic                  message_select;
      logic [1:0]            led_color;
      logic                  buzzer_drive;
      logic                  mute_clear;
   } rsp_payload_type;

endpackage

// ----- sv/mpa_div.sv -----
module mpa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mpa_pkg::NUM_BITS-1:0]  numerator,
   input  logic [mpa_pkg::CAL_BITS-1:0]  denominator,
   output logic                          done,
   output logic [mpa_pkg::TENTHS_BITS-1:0] quotient
);
   import mpa_pkg::*;

   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CAL_BITS-1:0]  rem_ff, rem_in;
   logic [NUM_BITS-1:0]  qn_ff, qn_in;
   logic [CAL_BITS-1:0]  den_ff, den_in;
   logic [CAL_BITS:0]    trial;
   logic [CAL_BITS:0]    diff;
   logic                 fits;
   logic                 last;

   assign trial = {rem_ff, qn_ff[NUM_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});
   assign last  = (cnt_ff == CNT_BITS'(NUM_BITS - 1));

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      qn_in      = qn_ff;
      den_in     = den_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         qn_in      = numerator;
         den_in     = denominator;
      end else if (running_ff) begin
         rem_in = fits ? diff[CAL_BITS-1:0] : trial[CAL_BITS-1:0];
         qn_in  = {qn_ff[NUM_BITS-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (last) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      qn_ff  <= qn_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = qn_ff[TENTHS_BITS-1:0];

endmodule

// ----- sv/moisture_percent_alarm.sv -----
// Soil moisture percentage with low-moisture alarm.
//
// Input channel (req_valid / req_stall / req_data): one raw converter sample
// and the user's mute flag per transfer. Result channel (rsp_valid /
// rsp_stall / rsp_data): one result per input, in order: whole percent,
// tenth digit, alarm, alert message select, LED color, buzzer and mute clear.
// Calibration (dry level, wet level, alarm threshold) is written through the
// csr_ port. Write only while no sample is in flight; this is not enforced.
//
// A new sample is taken in the cycle after the result is loaded, so no
// sample is accepted while one is in flight. The tenths come from a single
// restoring divider, one quotient bit per cycle over a 22-bit dividend,
// plus a multiply before it and the scale and split steps after it.
// The result sits in an output register: a new sample is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds that result internally and accepts nothing until it moves.
// Reset restores the calibration defaults, clears both alert phases and
// empties the result register.
module moisture_percent_alarm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mpa_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mpa_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_we,
   input  logic [mpa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mpa_pkg::CAL_BITS-1:0]      csr_wdata
);
   import mpa_pkg::*;

   state_type state_ff, state_in;

   logic [CAL_BITS-1:0]    dry_ff, dry_in;
   logic [CAL_BITS-1:0]    wet_ff, wet_in;
   logic [THR_BITS-1:0]    thr_ff, thr_in;
   logic                   msg_phase_ff, msg_phase_in;
   logic                   buz_phase_ff, buz_phase_in;

   logic [CAL_BITS-1:0]    diff_ff, diff_in;
   logic [CAL_BITS-1:0]    den_ff, den_in;
   logic                   mute_ff, mute_in;
   logic [NUM_BITS-1:0]    num_ff, num_in;
   logic [TENTHS_BITS-1:0] tenths_ff, tenths_in;
   logic [WHOLE_BITS-1:0]  whole_ff, whole_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   div_start;
   logic                   div_done;
   logic [TENTHS_BITS-1:0] quotient;
   logic                   load_out;
   logic                   out_free;

   logic [CMP_BITS-1:0]    sample_x, dry_x, wet_x, clamp_x;
   logic [DIV10_BITS-1:0]  scaled;
   logic [TENTHS_BITS-1:0] times_ten;
   logic                   is_alarm;

   mpa_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num_ff),
      .denominator (den_ff),
      .done        (div_done),
      .quotient    (quotient)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_SPLIT;
         ST_SPLIT: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_START: div_start = 1'b1;
         ST_SPLIT: load_out  = out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      dry_in = dry_ff;
      wet_in = wet_ff;
      thr_in = thr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DRY_LEVEL:       dry_in = csr_wdata;
            CSR_WET_LEVEL:       wet_in = csr_wdata;
            CSR_ALARM_THRESHOLD: thr_in = csr_wdata[THR_BITS-1:0];
            default:             thr_in = thr_ff;
         endcase
      end
   end

   // clamp on transfer
   always_comb begin
      sample_x = CMP_BITS'(req_data.raw_sample);
      dry_x    = CMP_BITS'(dry_ff);
      wet_x    = CMP_BITS'(wet_ff);
      clamp_x  = sample_x;
      if (clamp_x > dry_x) clamp_x = dry_x;
      if (clamp_x < wet_x) clamp_x = wet_x;
      diff_in = diff_ff;
      den_in  = den_ff;
      mute_in = mute_ff;
      if (accept) begin
         mute_in = req_data.mute_active;
         if (dry_ff > wet_ff) begin
            diff_in = dry_ff - clamp_x[CAL_BITS-1:0];
            den_in  = dry_ff - wet_ff;
         end else begin
            diff_in = '0;
            den_in  = CAL_BITS'(1);
         end
      end
   end

   assign num_in = (state_ff == ST_MUL) ? NUM_BITS'(NUM_BITS'(diff_ff) * SCALE_TENTHS)
                                        : num_ff;

   assign scaled    = DIV10_BITS'(quotient) * DIV10_MUL;
   assign tenths_in = (state_ff == ST_SCALE) ? quotient : tenths_ff;
   assign whole_in  = (state_ff == ST_SCALE) ? scaled[DIV10_SHIFT +: WHOLE_BITS] : whole_ff;

   assign times_ten = TENTHS_BITS'({whole_ff, 3'b000}) + TENTHS_BITS'({whole_ff, 1'b0});
   assign is_alarm  = (whole_ff < thr_ff);

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      msg_phase_in = msg_phase_ff;
      buz_phase_in = buz_phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.percent_whole   = whole_ff;
         rsp_data_in.percent_tenth   = DIGIT_BITS'(tenths_ff - times_ten);
         rsp_data_in.alarm           = is_alarm;
         rsp_data_in.message_select  = 1'b0;
         rsp_data_in.buzzer_drive    = 1'b0;
         rsp_data_in.mute_clear      = 1'b0;
         if (is_alarm) begin
            rsp_data_in.message_select = msg_phase_ff;
            rsp_data_in.led_color      = LED_RED;
            rsp_data_in.buzzer_drive   = buz_phase_ff && !mute_ff;
            msg_phase_in               = !msg_phase_ff;
            buz_phase_in               = !buz_phase_ff;
         end else begin
            rsp_data_in.mute_clear = 1'b1;
            rsp_data_in.led_color  = (whole_ff >= SATURATED_PERCENT) ? LED_WET : LED_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dry_ff       <= DRY_RESET;
         wet_ff       <= WET_RESET;
         thr_ff       <= THR_RESET;
         msg_phase_ff <= 1'b0;
         buz_phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dry_ff       <= dry_in;
         wet_ff       <= wet_in;
         thr_ff       <= thr_in;
         msg_phase_ff <= msg_phase_in;
         buz_phase_ff <= buz_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      mute_ff     <= mute_in;
      num_ff      <= num_in;
      tenths_ff   <= tenths_in;
      whole_ff    <= whole_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/mpa_checker.sv -----
module mpa_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  mpa_pkg::rsp_payload_type rsp_data
);
   import mpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a sample is in flight");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.percent_whole <= WHOLE_BITS'(100)
                 && rsp_data.percent_tenth <= DIGIT_BITS'(9))
      else $error("percent out of range");

   a_alarm_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.alarm == (rsp_data.led_color == LED_RED))
                 && (rsp_data.mute_clear == !rsp_data.alarm))
      else $error("alarm, led and mute clear disagree");

   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.alarm |-> !rsp_data.buzzer_drive && !rsp_data.message_select)
      else $error("alert outputs active without alarm");

endmodule

bind moisture_percent_alarm mpa_checker u_mpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
